>>> sv/pds_pkg.sv
// Shared types and constants for the difficulty scaler.
package pds_pkg;

   localparam int HEIGHT_W = 64;
   localparam int EDGE_W   = 6;
   localparam int SCALE_W  = 32;
   localparam int HASH_W   = 64;
   localparam int DIFF_W   = 64;

   localparam int DIV_STEPS = DIFF_W;

   localparam logic [EDGE_W-1:0] GRAPH_BASE_BITS     = 6'd24;
   localparam logic [EDGE_W-1:0] MIN_EDGE_BITS       = 6'd31;
   localparam logic [EDGE_W-1:0] SECONDARY_EDGE_BITS = 6'd29;

   localparam logic [HEIGHT_W-1:0] WEEK_BLOCKS = 64'd10080;
   localparam logic [HEIGHT_W-1:0] YEAR_BLOCKS = 64'd524160;
   // height at which even a proof of MIN_EDGE_BITS edge bits has fully decayed
   localparam logic [HEIGHT_W-1:0] FAR_BLOCKS  = 64'd836640;

   // (height - year) below the far mark fits in OFFSET_W bits; dividing by
   // a week is a shift by OFFSET_SHIFT then a multiply by RECIP
   localparam int OFFSET_W     = 19;
   localparam int OFFSET_SHIFT = 5;
   localparam int X_W          = OFFSET_W - OFFSET_SHIFT;
   localparam int RECIP_W      = 14;
   localparam logic [RECIP_W-1:0] RECIP = 14'd13316;
   localparam int RECIP_SHIFT  = 22;
   localparam int WEEKS_W      = 5;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [HASH_W-1:0] rem;
      logic [DIFF_W-1:0] quo;
      logic [HASH_W-1:0] divisor;
   } div_stage_type;

endpackage

>>> sv/pds_if.sv
// Request and response channel interfaces.
interface pds_req_if import pds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] block_height;
   logic [EDGE_W-1:0]   edge_bits;
   logic [SCALE_W-1:0]  secondary_scale;
   logic [HASH_W-1:0]   hash_word;

   modport source(output valid, block_height, edge_bits, secondary_scale, hash_word,
                  input ready);
   modport sink(input valid, block_height, edge_bits, secondary_scale, hash_word,
                output ready);
endinterface

interface pds_rsp_if import pds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIFF_W-1:0] difficulty;

   modport source(output valid, difficulty, input ready);
   modport sink(input valid, difficulty, output ready);
endinterface

>>> sv/pow_difficulty_scaler_unit.sv
// Proof-of-work difficulty scaler: one share per cycle unless stalled
// by the output buffer. Four front-end stages form the scale (graph weight
// with weekly decay, or the secondary scale at SECONDARY_EDGE_BITS), then a row of
// 64 identical cells performs one long-division step each on (scale << 64)
// by the hash word. The whole row advances together; a two-entry output
// buffer lets the row keep accepting while a response waits, and the
// request side stalls only once both entries hold responses. A zero hash word
// or a quotient that would overflow returns all ones.
module pow_difficulty_scaler_unit import pds_pkg::*; (
   input logic       clock,
   input logic       reset,
   pds_req_if.sink   req_bus,
   pds_rsp_if.source rsp_bus
);

   logic          advance;
   div_stage_type chain [DIV_STEPS+1];
   logic [DIFF_W-1:0] result;

   assign req_bus.ready = advance;

   pds_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_bus.valid),
      .block_height    (req_bus.block_height),
      .edge_bits       (req_bus.edge_bits),
      .secondary_scale (req_bus.secondary_scale),
      .hash_word       (req_bus.hash_word),
      .seed            (chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      pds_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .prev    (chain[i]),
         .next    (chain[i+1])
      );
   end

   assign result = chain[DIV_STEPS].sat ? '1 : chain[DIV_STEPS].quo;

   pds_out_skid u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain[DIV_STEPS].valid && advance),
      .in_data  (result),
      .advance  (advance),
      .rsp      (rsp_bus)
   );

endmodule

>>> sv/pds_scale.sv
// Front end: computes the scale and seeds the divider chain.
module pds_scale import pds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [HEIGHT_W-1:0] block_height,
   input  logic [EDGE_W-1:0]   edge_bits,
   input  logic [SCALE_W-1:0]  secondary_scale,
   input  logic [HASH_W-1:0]   hash_word,
   output div_stage_type       seed
);

   logic                v1_ff, v1_in, v2_ff, v3_ff, v4_ff;
   logic [EDGE_W-1:0]   eb1_ff, eb2_ff;
   logic [SCALE_W-1:0]  sec1_ff, sec2_ff, scale3_ff, scale3_in;
   logic [HASH_W-1:0]   h1_ff, h2_ff, h3_ff, h4_ff;
   logic                ge1_ff, ge2_ff, far1_ff, far2_ff;
   logic [X_W-1:0]      x1_ff, x1_in;
   logic [WEEKS_W-1:0]  wk2_ff, wk2_in;
   logic                sat4_ff, sat4_in;
   logic [SCALE_W-1:0]  scale4_ff;
   logic [OFFSET_W-1:0] offset;
   logic [X_W+RECIP_W-1:0] prod;
   logic [EDGE_W-1:0]   weeks, count, sh;
   logic [SCALE_W-1:0]  weight;

   assign v1_in  = in_valid;
   assign offset = block_height[OFFSET_W-1:0] - YEAR_BLOCKS[OFFSET_W-1:0];
   assign x1_in  = offset[OFFSET_W-1:OFFSET_SHIFT];

   assign prod   = {{RECIP_W{1'b0}}, x1_ff} * {{X_W{1'b0}}, RECIP};
   assign wk2_in = prod[RECIP_SHIFT+WEEKS_W-1:RECIP_SHIFT];

   always_comb begin
      weeks = {1'b0, wk2_ff} + 6'd1;
      if (!(ge2_ff && eb2_ff <= MIN_EDGE_BITS)) begin
         count = eb2_ff;
      end else if (far2_ff || eb2_ff <= weeks) begin
         count = '0;
      end else begin
         count = eb2_ff - weeks;
      end
      sh     = eb2_ff - GRAPH_BASE_BITS;
      weight = (32'd2 << sh) * {{(SCALE_W-EDGE_W){1'b0}}, count};
      if (eb2_ff == SECONDARY_EDGE_BITS) begin
         scale3_in = sec2_ff;
      end else if (eb2_ff < GRAPH_BASE_BITS) begin
         scale3_in = '0;
      end else begin
         scale3_in = weight;
      end
   end

   assign sat4_in = (h3_ff == '0) || ({{(HASH_W-SCALE_W){1'b0}}, scale3_ff} >= h3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         eb1_ff    <= edge_bits;
         sec1_ff   <= secondary_scale;
         h1_ff     <= hash_word;
         ge1_ff    <= block_height >= YEAR_BLOCKS;
         far1_ff   <= block_height >= FAR_BLOCKS;
         x1_ff     <= x1_in;
         eb2_ff    <= eb1_ff;
         sec2_ff   <= sec1_ff;
         h2_ff     <= h1_ff;
         ge2_ff    <= ge1_ff;
         far2_ff   <= far1_ff;
         wk2_ff    <= wk2_in;
         scale3_ff <= scale3_in;
         h3_ff     <= h2_ff;
         scale4_ff <= scale3_ff;
         sat4_ff   <= sat4_in;
         h4_ff     <= h3_ff;
      end
   end

   assign seed.valid   = v4_ff;
   assign seed.sat     = sat4_ff;
   assign seed.rem     = {{(HASH_W-SCALE_W){1'b0}}, scale4_ff};
   assign seed.quo     = '0;
   assign seed.divisor = h4_ff;

endmodule

>>> sv/pds_div_cell.sv
// One restoring division step of the divider chain.
module pds_div_cell import pds_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  div_stage_type prev,
   output div_stage_type next
);

   logic            valid_ff;
   div_stage_type   data_ff, data_in;
   logic [HASH_W:0] shifted;
   logic [HASH_W:0] diff;
   logic            take;

   always_comb begin
      shifted = {prev.rem, 1'b0};
      diff    = shifted - {1'b0, prev.divisor};
      take    = shifted >= {1'b0, prev.divisor};
      data_in         = prev;
      data_in.rem     = take ? diff[HASH_W-1:0] : shifted[HASH_W-1:0];
      data_in.quo     = {prev.quo[DIFF_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      next       = data_ff;
      next.valid = valid_ff;
   end

endmodule

>>> sv/pds_out_skid.sv
// Output register with one spare entry; stalls the chain when the spare fills.
module pds_out_skid import pds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DIFF_W-1:0] in_data,
   output logic              advance,
   pds_rsp_if.source         rsp
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIFF_W-1:0] rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DIFF_W-1:0] skid_data_ff, skid_data_in;

   assign advance = !skid_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp.ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = in_valid;
            skid_data_in  = in_data;
         end else begin
            rsp_valid_in  = in_valid;
            rsp_data_in   = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.difficulty = rsp_data_ff;

endmodule

>>> sv/pds_checker.sv
// Port-level checks for the difficulty scaler, bound to the top level.
module pds_checker import pds_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIFF_W-1:0] rsp_difficulty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_difficulty))
      else $error("response payload changed while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no response pending");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind pow_difficulty_scaler_unit pds_checker u_pds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_difficulty (rsp_bus.difficulty)
);
